// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent checks in the Hybla window update RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HCU_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define HCU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define HCU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hcu_pkg.sv
// ----------------------------------------------------------------------------
// Hybla window update package
// Constants, field layout, command codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package hcu_pkg;

    // Smoothed RTT is kept scaled by two to the power of this shift.
    localparam int unsigned SRTT_SHIFT = 2;

    localparam logic [31:0] RHO_MIN_EIGHTHS = 32'd8;
    localparam logic [28:0] RHO_EXP_CAP     = 29'd16;
    localparam logic [31:0] FRAC_ONE        = 32'd128;

    localparam logic [15:0] RTT_REF_RESET  = 16'd37;
    localparam logic [31:0] MAX_CWND_RESET = 32'd1073725440;

    // Request layout on the slave side.
    localparam int unsigned TDATA_W      = 120;
    localparam int unsigned TUSER_W      = 2;
    localparam int unsigned SRTT_LSB     = 0;
    localparam int unsigned CWND_LSB     = 32;
    localparam int unsigned SSTH_LSB     = 64;
    localparam int unsigned SEG_LSB      = 96;
    localparam int unsigned WLIM_BIT     = 112;
    localparam int unsigned RECOV_BIT    = 113;
    localparam int unsigned OUT_TDATA_W  = 32;

    // Command codes carried in tuser.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_CONG  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_RTT_REF  = 1'b0;
    localparam logic REG_MAX_CWND = 1'b1;

    typedef enum logic [2:0] {
        MUL_RHO_SQ,
        MUL_RHO_SEG,
        MUL_SQ_SEG,
        MUL_INC_SEG,
        MUL_ACK_SEG
    } mul_sel_t;

    typedef enum logic {
        DIV_RHO,
        DIV_AVOID
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        mul_sel_t mul_sel;
        logic     rho_wr;
        logic     sq_wr;
        logic     slow_inc_wr;
        logic     avoid_inc_wr;
        logic     grow_add;
        logic     ack_add;
        logic     clamp;
        logic     cong_clear;
        logic     res_start;
        logic     out_load;
    } dp_ctl_t;

    typedef struct packed {
        logic is_start;
        logic is_ack;
        logic is_cong;
        logic need_rho;
        logic grow;
        logic slow;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } dp_sts_t;

    // Two to the power of eighths, in 1/128 units.
    function automatic logic [7:0] frac_pow(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'd128;
            3'd1:    val = 8'd139;
            3'd2:    val = 8'd152;
            3'd3:    val = 8'd165;
            3'd4:    val = 8'd181;
            3'd5:    val = 8'd197;
            3'd6:    val = 8'd215;
            3'd7:    val = 8'd234;
            default: val = 8'd128;
        endcase
        return val;
    endfunction

endpackage

// File: hw/rtl/hybla_cwnd_update_unit.sv
// ----------------------------------------------------------------------------
// Hybla congestion window update unit
// Top level: request and result streams, configuration port, control and data.
// ----------------------------------------------------------------------------
// The unit updates the congestion window of one connection per request, following
// the Hybla scheme. A request carries a command in tuser (connection start, ack
// received or congestion signal) and, in tdata, the smoothed RTT, the current
// window, the slow start threshold, the segment size and the window limited and
// recovery flags. Each request yields exactly one result on the master side: the
// new window in bytes. Requests are handled one at a time by a sequencer that
// steers a single 32-bit multiplier and a restoring divider producing one quotient
// bit per cycle. A congestion signal, or an ack that neither refreshes rho nor
// grows the window, takes the shortest path; an ack that first refreshes rho and
// then grows the window in congestion avoidance runs both divides and is the
// slowest request. The result sits in an output register, so the next request is
// taken while an earlier result still waits for tready; a new result waits for
// that register to empty. The configuration port is always ready; the reference
// RTT and window clamp should only be written while no request is in flight.
// ----------------------------------------------------------------------------

module hybla_cwnd_update_unit
    import hcu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0: srtt[31:0], cwnd_in[63:32], ssthresh[95:64], max_seg[111:96],
    // window_limited[112], fast_recovery[113], zero fill [119:114].
    input  logic [TDATA_W-1:0]     s_tdata,
    // From bit 0: cmd[1:0].
    input  logic [TUSER_W-1:0]     s_tuser,

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: cwnd_out[31:0].
    output logic [OUT_TDATA_W-1:0] m_tdata,

    // Configuration writes: index 0 is rtt_ref, index 1 is max_cwnd.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    // Configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller owns sequencing and the request handshake; it never looks
    // at payload, only at the status flags that the datapath derives from it.
    hcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath holds the latched request, the per-connection rho state, the
    // fraction accumulator and ack counter, the configuration and the output
    // register.
    hcu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hw/rtl/hcu_div.sv
// ----------------------------------------------------------------------------
// Hybla serial divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcu_div
    import hcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        fits;

    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[31:0] : rem_sh[31:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `HCU_ASSERT_NXT(a_div_start_busy, start, busy_reg, "divider did not start")
    `HCU_ASSERT_IMP(a_div_done_idle, done_reg, !busy_reg, "divider done while busy")

endmodule

// File: hw/rtl/hcu_datapath.sv
// ----------------------------------------------------------------------------
// Hybla window update datapath
// Request registers, connection state, shared multiplier, divider and output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcu_datapath
    import hcu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_ctl_t                ctl,
    output dp_sts_t                sts,
    input  logic [TDATA_W-1:0]     s_tdata,
    input  logic [TUSER_W-1:0]     s_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Latched request.
    logic [1:0]  cmd_reg;
    logic [31:0] srtt_reg;
    logic [31:0] ssth_reg;
    logic [15:0] seg_reg;
    logic        wlim_reg;
    logic        recov_reg;
    logic        slow_reg;

    // Working window, increment and product.
    logic [31:0] cw_reg;
    logic [31:0] inc_reg;
    logic [31:0] prod_reg;

    // Connection state.
    logic [28:0] rho_int_reg;
    logic [31:0] rho_eighths_reg;
    logic [31:0] rho_sq_reg;
    logic [31:0] min_srtt_reg;
    logic [6:0]  frac_reg;
    logic [31:0] ack_count_reg;

    // Configuration.
    logic [15:0] rtt_ref_reg;
    logic [31:0] max_cwnd_reg;

    // Output stage.
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_low;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_quo;
    logic [31:0] rho_new;
    logic [4:0]  exp_sh;
    logic [31:0] slow_inc;
    logic [7:0]  frac_sum;
    logic [31:0] cw_grow;
    logic [31:0] ssth_cap;
    logic [31:0] cw_cap;
    logic [31:0] cw_clamp;
    logic        lt_min;

    // Shared multiplier; only the low word is kept, so products wrap at 32 bits.
    always_comb
    begin
        case (ctl.mul_sel)
            MUL_RHO_SQ:
            begin
                mul_a = rho_eighths_reg;
                mul_b = rho_eighths_reg;
            end
            MUL_RHO_SEG:
            begin
                mul_a = {3'b000, rho_int_reg};
                mul_b = {16'h0000, seg_reg};
            end
            MUL_SQ_SEG:
            begin
                mul_a = rho_sq_reg;
                mul_b = {16'h0000, seg_reg};
            end
            MUL_INC_SEG:
            begin
                mul_a = {7'b0000000, inc_reg[31:7]};
                mul_b = {16'h0000, seg_reg};
            end
            MUL_ACK_SEG:
            begin
                mul_a = ack_count_reg;
                mul_b = {16'h0000, seg_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_low = mul_a * mul_b;

    always_comb
    begin
        case (ctl.div_sel)
            DIV_RHO:
            begin
                div_dividend = srtt_reg >> SRTT_SHIFT;
                div_divisor  = (rtt_ref_reg == 16'h0000) ? 32'd1 : {16'h0000, rtt_ref_reg};
            end
            DIV_AVOID:
            begin
                div_dividend = prod_reg;
                div_divisor  = cw_reg;
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = cw_reg;
            end
        endcase
    end

    hcu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rho_new = (div_quo < RHO_MIN_EIGHTHS) ? RHO_MIN_EIGHTHS : div_quo;

    // Slow start: 2^rho in 1/128 units, less one.
    assign exp_sh   = (rho_int_reg < RHO_EXP_CAP) ? rho_int_reg[4:0] : RHO_EXP_CAP[4:0];
    assign slow_inc = ({24'h0, frac_pow(rho_eighths_reg[2:0])} << exp_sh) - FRAC_ONE;

    // Whole segments from the product, one more when the fraction carries.
    assign frac_sum = {1'b0, frac_reg} + {1'b0, inc_reg[6:0]};
    assign cw_grow  = cw_reg + prod_reg + (frac_sum[7] ? {16'h0000, seg_reg} : 32'h0);

    assign ssth_cap = ssth_reg + 32'd1;
    assign cw_cap   = (slow_reg && (cw_reg > ssth_cap)) ? ssth_cap : cw_reg;
    assign cw_clamp = (cw_cap > max_cwnd_reg) ? max_cwnd_reg : cw_cap;

    assign lt_min = (srtt_reg < min_srtt_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= s_tuser;
            srtt_reg  <= s_tdata[SRTT_LSB +: 32];
            ssth_reg  <= s_tdata[SSTH_LSB +: 32];
            seg_reg   <= s_tdata[SEG_LSB +: 16];
            wlim_reg  <= s_tdata[WLIM_BIT];
            recov_reg <= s_tdata[RECOV_BIT];
            slow_reg  <= (s_tdata[CWND_LSB +: 32] <= s_tdata[SSTH_LSB +: 32]);
        end

        prod_reg <= mul_low;

        if (ctl.load)
            cw_reg <= s_tdata[CWND_LSB +: 32];
        else if (ctl.res_start)
            cw_reg <= prod_reg;
        else if (ctl.grow_add)
            cw_reg <= cw_grow;
        else if (ctl.ack_add && (inc_reg == 32'h0) && (prod_reg >= cw_reg))
            cw_reg <= cw_reg + {16'h0000, seg_reg};
        else if (ctl.clamp)
            cw_reg <= cw_clamp;

        if (ctl.slow_inc_wr)
            inc_reg <= slow_inc;
        else if (ctl.avoid_inc_wr)
            inc_reg <= div_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_int_reg     <= '0;
            rho_eighths_reg <= '0;
            rho_sq_reg      <= '0;
            min_srtt_reg    <= '0;
            frac_reg        <= '0;
            ack_count_reg   <= '0;
            rtt_ref_reg     <= RTT_REF_RESET;
            max_cwnd_reg    <= MAX_CWND_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_RTT_REF))
                rtt_ref_reg <= cfg_data[15:0];
            if (cfg_valid && (cfg_index == REG_MAX_CWND))
                max_cwnd_reg <= cfg_data;

            if (ctl.rho_wr)
            begin
                rho_eighths_reg <= rho_new;
                rho_int_reg     <= rho_new[31:3];
                if (cmd_reg == CMD_START || lt_min)
                    min_srtt_reg <= srtt_reg;
                if (cmd_reg == CMD_START)
                    frac_reg <= '0;
            end

            if (ctl.sq_wr)
                rho_sq_reg <= {prod_reg[30:0], 1'b0};

            if (ctl.grow_add)
                frac_reg <= frac_sum[6:0];

            if (ctl.avoid_inc_wr && (div_quo < FRAC_ONE))
                ack_count_reg <= ack_count_reg + 32'd1;
            else if (ctl.grow_add && frac_sum[7])
                ack_count_reg <= '0;
            else if (ctl.ack_add && (inc_reg == 32'h0) && (prod_reg >= cw_reg))
                ack_count_reg <= '0;
            else if (ctl.cong_clear)
                ack_count_reg <= '0;

            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            out_data_reg <= cw_reg;
    end

    assign sts.is_start = (cmd_reg == CMD_START);
    assign sts.is_ack   = (cmd_reg == CMD_ACK);
    assign sts.is_cong  = (cmd_reg == CMD_CONG);
    assign sts.grow     = wlim_reg && !recov_reg;
    assign sts.need_rho = sts.is_start ||
                          (sts.is_ack && (lt_min || (sts.grow && (rho_int_reg == 29'h0))));
    assign sts.slow     = slow_reg;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `HCU_ASSERT(a_rho_consistent, rho_int_reg == rho_eighths_reg[31:3], "rho halves disagree")
    `HCU_ASSERT_NXT(a_rho_floor, ctl.rho_wr, rho_eighths_reg >= RHO_MIN_EIGHTHS, "rho below floor")

endmodule

// File: hw/rtl/hcu_ctrl.sv
// ----------------------------------------------------------------------------
// Hybla window update controller
// Sequences one request through the rho, start window, increment and growth steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcu_ctrl
    import hcu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_ctl_t ctl
);

    typedef enum logic [16:0] {
        ST_IDLE     = 17'b00000000000000001,
        ST_EVAL     = 17'b00000000000000010,
        ST_RHO_DIV  = 17'b00000000000000100,
        ST_RHO_SQ   = 17'b00000000000001000,
        ST_SQ_WR    = 17'b00000000000010000,
        ST_ROUTE    = 17'b00000000000100000,
        ST_START_MUL= 17'b00000000001000000,
        ST_START_WR = 17'b00000000010000000,
        ST_AV_MUL   = 17'b00000000100000000,
        ST_AV_START = 17'b00000001000000000,
        ST_AV_DIV   = 17'b00000010000000000,
        ST_GROW_MUL = 17'b00000100000000000,
        ST_GROW_ADD = 17'b00001000000000000,
        ST_ACK_MUL  = 17'b00010000000000000,
        ST_ACK_ADD  = 17'b00100000000000000,
        ST_CLAMP    = 17'b01000000000000000,
        ST_FINISH   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.div_sel = DIV_RHO;
        ctl.mul_sel = MUL_RHO_SQ;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.need_rho)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_RHO_DIV;
                end
                else
                    state_next = ST_ROUTE;
            end
            ST_RHO_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.rho_wr = 1'b1;
                    state_next = ST_RHO_SQ;
                end
            end
            ST_RHO_SQ:
            begin
                ctl.mul_sel = MUL_RHO_SQ;
                state_next  = ST_SQ_WR;
            end
            ST_SQ_WR:
            begin
                ctl.sq_wr  = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (sts.is_start)
                    state_next = ST_START_MUL;
                else if (sts.is_ack && sts.grow)
                begin
                    if (sts.slow)
                    begin
                        ctl.slow_inc_wr = 1'b1;
                        state_next      = ST_GROW_MUL;
                    end
                    else
                        state_next = ST_AV_MUL;
                end
                else
                begin
                    ctl.cong_clear = sts.is_cong;
                    state_next     = ST_FINISH;
                end
            end
            ST_START_MUL:
            begin
                ctl.mul_sel = MUL_RHO_SEG;
                state_next  = ST_START_WR;
            end
            ST_START_WR:
            begin
                ctl.res_start = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_AV_MUL:
            begin
                ctl.mul_sel = MUL_SQ_SEG;
                state_next  = ST_AV_START;
            end
            ST_AV_START:
            begin
                ctl.div_sel   = DIV_AVOID;
                ctl.div_start = 1'b1;
                state_next    = ST_AV_DIV;
            end
            ST_AV_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.avoid_inc_wr = 1'b1;
                    state_next       = ST_GROW_MUL;
                end
            end
            ST_GROW_MUL:
            begin
                ctl.mul_sel = MUL_INC_SEG;
                state_next  = ST_GROW_ADD;
            end
            ST_GROW_ADD:
            begin
                ctl.grow_add = 1'b1;
                state_next   = ST_ACK_MUL;
            end
            ST_ACK_MUL:
            begin
                ctl.mul_sel = MUL_ACK_SEG;
                state_next  = ST_ACK_ADD;
            end
            ST_ACK_ADD:
            begin
                ctl.ack_add = 1'b1;
                state_next  = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                ctl.clamp  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `HCU_ASSERT_IMP(a_div_start_idle, ctl.div_start, !sts.div_busy, "divider restarted while busy")
    `HCU_ASSERT_IMP(a_out_no_overrun, ctl.out_load, !sts.out_busy, "result overwritten")

endmodule
